// ===== rtl/core/ad16_pkg.sv =====
package ad16_pkg;

  localparam int AD16_BUFFER_BITS = 64;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_START  = 2'd1,
    REQ_TARGET = 2'd2,
    REQ_NARROW = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LOW_BITS = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_PUSH,
    DP_START,
    DP_MUL_T,
    DP_MUL_H,
    DP_MUL_L,
    DP_PREP_T,
    DP_PREP_N,
    DP_DIV_STEP,
    DP_WB_T,
    DP_WB_H,
    DP_WB_L,
    DP_RENORM
  } dp_op_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_START,
    S_TMUL,
    S_TPREP,
    S_TDIV,
    S_TWB,
    S_HMUL,
    S_HPREP,
    S_HDIV,
    S_HWB,
    S_LMUL,
    S_LPREP,
    S_LDIV,
    S_LWB,
    S_RENORM,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    logic    load_out;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic lt16;
    logic total_zero;
    logic hi_eq_total;
    logic lo_zero;
    logic div_last;
    logic renorm_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/ad16_if.sv =====
interface ad16_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] code_word;
  logic [15:0] cum_low;
  logic [16:0] cum_high;
  logic [16:0] freq_total;

  modport source (output valid, req_type, code_word, cum_low, cum_high, freq_total,
                  input ready);
  modport sink (input valid, req_type, code_word, cum_low, cum_high, freq_total,
                output ready);
endinterface

interface ad16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] target;
  logic [1:0]  status;
  logic [6:0]  bits_held;

  modport source (output valid, target, status, bits_held, input ready);
  modport sink (input valid, target, status, bits_held, output ready);
endinterface

// ===== rtl/core/ad16_dp.sv =====
module ad16_dp
  import ad16_pkg::*;
#(
  parameter int BUFFER_BITS = AD16_BUFFER_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_code_word,
  input  logic [15:0] in_cum_low,
  input  logic [16:0] in_cum_high,
  input  logic [16:0] in_freq_total,
  output logic [15:0] out_target,
  output logic [1:0]  out_status,
  output logic [6:0]  out_bits_held
);

  localparam int CW = $clog2(BUFFER_BITS + 1);

  // Captured request
  logic [1:0]  req_r;
  logic [15:0] word_r;
  logic [15:0] lo_r;
  logic [16:0] hi_r;
  logic [16:0] tot_r;
  logic [15:0] span_r;   // high - low before the narrow starts

  // Decoder state
  logic [15:0]            low_r, low_nxt;
  logic [15:0]            high_r, high_nxt;
  logic [15:0]            code_r, code_nxt;
  logic [BUFFER_BITS-1:0] fifo_r, fifo_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;

  // Arithmetic
  logic [33:0] prod_r;
  logic [33:0] num_r;
  logic [16:0] rem_r;
  logic [16:0] div_r;
  logic [15:0] quo_r;
  logic        sat_r;
  logic [5:0]  dcnt_r;
  logic [3:0]  rcnt_r;
  logic [15:0] target_r;

  // Output register
  logic [15:0] ot_r;
  logic [1:0]  os_r;
  logic [6:0]  ob_r;

  // Interval terms
  logic [15:0] rng16, c16, span16;
  logic [16:0] rng17, c17;
  logic [16:0] mul_a, mul_b;
  logic [33:0] nm1;
  logic [17:0] rem_sh;
  logic        rem_ge;
  logic [17:0] rem_sub;
  logic [15:0] word_rev;
  logic [BUFFER_BITS-1:0] word_ext;
  logic [CW+15:0] cnt_plus;
  logic [CW+6:0]  cnt_ext;
  logic        e3, brk;
  logic [15:0] rl, rh, rc;
  logic        pop_bit;

  always_comb begin
    rng16  = high_r - low_r + 16'd1;
    c16    = code_r - low_r + 16'd1;
    span16 = high_r - low_r;
    rng17  = (rng16 == 16'd0) ? 17'h10000 : {1'b0, rng16};
    c17    = (c16 == 16'd0) ? 17'h10000 : {1'b0, c16};
  end

  // Shared multiplier operand select
  always_comb begin
    case (cmd.op)
      DP_MUL_T: begin
        mul_a = c17;
        mul_b = tot_r;
      end
      DP_MUL_H: begin
        mul_a = {1'b0, span_r} + 17'd1;
        mul_b = hi_r;
      end
      default: begin
        mul_a = {1'b0, span_r} + 17'd1;
        mul_b = {1'b0, lo_r};
      end
    endcase
  end

  assign nm1 = prod_r - 34'd1;

  // Restoring divider step
  always_comb begin
    rem_sh  = {rem_r, num_r[33]};
    rem_ge  = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
  end

  // Push alignment
  always_comb begin
    for (int i = 0; i < 16; i++) word_rev[i] = word_r[15 - i];
    word_ext = '0;
    word_ext[15:0] = word_rev;
    cnt_plus = {16'd0, cnt_r} + (CW + 16)'(16);
    cnt_ext  = {7'd0, cnt_r};
  end

  // Renormalization step
  always_comb begin
    e3  = (low_r >= 16'h4000) && (high_r < 16'hC000);
    brk = !e3 && (high_r >= 16'h8000) && (low_r < 16'h8000);
    rl  = e3 ? low_r - 16'h4000 : low_r;
    rh  = e3 ? high_r - 16'h4000 : high_r;
    rc  = e3 ? code_r - 16'h4000 : code_r;
    pop_bit = fifo_r[0];
  end

  // Next state of the decoder registers
  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    code_nxt = code_r;
    fifo_nxt = fifo_r;
    cnt_nxt  = cnt_r;
    case (cmd.op)
      DP_PUSH: begin
        fifo_nxt = fifo_r | (word_ext << cnt_r);
        cnt_nxt  = cnt_r + CW'(16);
      end
      DP_START: begin
        low_nxt  = 16'h0000;
        high_nxt = 16'hFFFF;
        for (int i = 0; i < 16; i++) code_nxt[15 - i] = fifo_r[i];
        fifo_nxt = fifo_r >> 16;
        cnt_nxt  = cnt_r - CW'(16);
      end
      DP_WB_H: high_nxt = low_r + quo_r - 16'd1;
      DP_WB_L: low_nxt = low_r + quo_r;
      DP_RENORM: begin
        if (!brk) begin
          low_nxt  = {rl[14:0], 1'b0};
          high_nxt = {rh[14:0], 1'b1};
          code_nxt = {rc[14:0], pop_bit};
          fifo_nxt = fifo_r >> 1;
          if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= 16'h0000;
      high_r <= 16'hFFFF;
      code_r <= 16'h0000;
      fifo_r <= '0;
      cnt_r  <= '0;
      rcnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      code_r <= code_nxt;
      fifo_r <= fifo_nxt;
      cnt_r  <= cnt_nxt;
      if (cmd.op == DP_CAPTURE) rcnt_r <= '0;
      else if (cmd.op == DP_RENORM) rcnt_r <= rcnt_r + 4'd1;
      if (cmd.op == DP_PREP_T) dcnt_r <= 6'd15;
      else if (cmd.op == DP_PREP_N) dcnt_r <= 6'd33;
      else if (cmd.op == DP_DIV_STEP) dcnt_r <= dcnt_r - 6'd1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        req_r    <= in_req_type;
        word_r   <= in_code_word;
        lo_r     <= in_cum_low;
        hi_r     <= in_cum_high;
        tot_r    <= in_freq_total;
        span_r   <= span16;
        target_r <= 16'd0;
      end
      DP_MUL_T, DP_MUL_H, DP_MUL_L: prod_r <= mul_a * mul_b;
      DP_PREP_T: begin
        sat_r <= nm1[33:16] >= {1'b0, rng17};
        rem_r <= nm1[32:16];
        num_r <= {nm1[15:0], 18'd0};
        div_r <= rng17;
      end
      DP_PREP_N: begin
        sat_r <= 1'b0;
        rem_r <= '0;
        num_r <= prod_r;
        div_r <= tot_r;
      end
      DP_DIV_STEP: begin
        rem_r <= rem_ge ? rem_sub[16:0] : rem_sh[16:0];
        num_r <= {num_r[32:0], 1'b0};
        quo_r <= {quo_r[14:0], rem_ge};
      end
      DP_WB_T: target_r <= sat_r ? 16'hFFFF : quo_r;
      default: ;
    endcase
    if (cmd.load_out) begin
      ot_r <= target_r;
      os_r <= cmd.status;
      ob_r <= cnt_ext[6:0];
    end
  end

  always_comb begin
    stat.req         = req_t'(req_r);
    stat.full        = cnt_plus > (CW + 16)'(BUFFER_BITS);
    stat.lt16        = cnt_r < CW'(16);
    stat.total_zero  = tot_r == 17'd0;
    stat.hi_eq_total = hi_r == tot_r;
    stat.lo_zero     = lo_r == 16'd0;
    stat.div_last    = dcnt_r == 6'd0;
    stat.renorm_last = brk || (rcnt_r == 4'd15);
  end

  assign out_target    = ot_r;
  assign out_status    = os_r;
  assign out_bits_held = ob_r;

endmodule

// ===== rtl/core/ad16_ctrl.sv =====
module ad16_ctrl
  import ad16_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_DECODE;
          status_nxt = ST_OK;
        end
      end
      S_DECODE: begin
        case (stat.req)
          REQ_PUSH: begin
            if (stat.full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_PUSH;
            end
          end
          REQ_START: begin
            if (stat.lt16) begin
              status_nxt = ST_LOW_BITS;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_START;
            end
          end
          REQ_TARGET: state_nxt = stat.total_zero ? S_DONE : S_TMUL;
          default: begin
            if (stat.lt16) begin
              status_nxt = ST_LOW_BITS;
              state_nxt  = S_DONE;
            end else if (stat.total_zero) begin
              state_nxt = S_DONE;
            end else if (!stat.hi_eq_total) begin
              state_nxt = S_HMUL;
            end else begin
              state_nxt = stat.lo_zero ? S_RENORM : S_LMUL;
            end
          end
        endcase
      end
      S_PUSH, S_START: state_nxt = S_DONE;
      S_TMUL:  state_nxt = S_TPREP;
      S_TPREP: state_nxt = S_TDIV;
      S_TDIV:  if (stat.div_last) state_nxt = S_TWB;
      S_TWB:   state_nxt = S_DONE;
      S_HMUL:  state_nxt = S_HPREP;
      S_HPREP: state_nxt = S_HDIV;
      S_HDIV:  if (stat.div_last) state_nxt = S_HWB;
      S_HWB:   state_nxt = stat.lo_zero ? S_RENORM : S_LMUL;
      S_LMUL:  state_nxt = S_LPREP;
      S_LPREP: state_nxt = S_LDIV;
      S_LDIV:  if (stat.div_last) state_nxt = S_LWB;
      S_LWB:   state_nxt = S_RENORM;
      S_RENORM: if (stat.renorm_last) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op       = DP_NONE;
    cmd.load_out = 1'b0;
    cmd.status   = status_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_CAPTURE;
      end
      S_PUSH:  cmd.op = DP_PUSH;
      S_START: cmd.op = DP_START;
      S_TMUL:  cmd.op = DP_MUL_T;
      S_HMUL:  cmd.op = DP_MUL_H;
      S_LMUL:  cmd.op = DP_MUL_L;
      S_TPREP: cmd.op = DP_PREP_T;
      S_HPREP, S_LPREP: cmd.op = DP_PREP_N;
      S_TDIV, S_HDIV, S_LDIV: cmd.op = DP_DIV_STEP;
      S_TWB:   cmd.op = DP_WB_T;
      S_HWB:   cmd.op = DP_WB_H;
      S_LWB:   cmd.op = DP_WB_L;
      S_RENORM: cmd.op = DP_RENORM;
      S_DONE:  cmd.load_out = out_free;
      default: ;
    endcase
  end

  // Output beat flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/arith_decoder_16bit_unit.sv =====
// 16-bit arithmetic decoder with E1/E2/E3 renormalization.
// in_ch: one beat per request (push word, start, decode target, narrow),
//   taken when valid and ready are high; ready is high only while idle.
// out_ch: one result beat per request (target, status, bits_held), held in
//   an output register until taken; the next request may be accepted while
//   that beat still waits.
// Steps per request: push and start update the bit buffer and decoder state;
//   flagged requests and a zero total go straight to the result; decode
//   target: a 17x17 multiply, then 16 steps of a radix-2 divider; narrow:
//   up to two multiplies and two 34-step divisions, then up to 16
//   renormalization doublings. The divider is shared, one bit per cycle.
// Reset: interval [0, 0xFFFF], code value 0, bit buffer empty, no beat out.
// A stalled receiver holds the result; the block finishes the request after
//   it only once the output register is free.
module arith_decoder_16bit_unit
  import ad16_pkg::*;
#(
  parameter int BUFFER_BITS = AD16_BUFFER_BITS
) (
  input logic clk,
  input logic rst_n,
  ad16_in_if.sink    in_ch,
  ad16_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ad16_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ad16_dp #(
    .BUFFER_BITS (BUFFER_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_ch.req_type),
    .in_code_word  (in_ch.code_word),
    .in_cum_low    (in_ch.cum_low),
    .in_cum_high   (in_ch.cum_high),
    .in_freq_total (in_ch.freq_total),
    .out_target    (out_ch.target),
    .out_status    (out_ch.status),
    .out_bits_held (out_ch.bits_held)
  );

endmodule
